>>> sv/rvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I execute package
// Shared constants, opcodes and result codes for the integer execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned REG_COUNT_DEFAULT = 32;

   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_FENCE  = 7'h0F;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [4:0] SHAMT_MASK = 5'h1F;

   typedef enum logic [2:0] {
      KIND_RETIRED    = 3'd0,
      KIND_LOAD       = 3'd1,
      KIND_STORE      = 3'd2,
      KIND_ILLEGAL    = 3'd3,
      KIND_UNEXPECTED = 3'd4
   } kind_type;

   localparam logic ITEM_INSTR = 1'b0;
   localparam logic ITEM_LOAD_DATA = 1'b1;

   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   typedef struct packed {
      logic        we;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_write_type;

endpackage

>>> sv/rvx_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one instruction word or load data item.
// ----------------------------------------------------------------------------
interface rvx_req_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [31:0] instr_word;
   logic [31:0] load_data;
   modport source (output valid, item_kind, instr_word, load_data, input ready);
   modport sink (input valid, item_kind, instr_word, load_data, output ready);
endinterface

>>> sv/rvx_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one execution result item.
// ----------------------------------------------------------------------------
interface rvx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [31:0] mem_address;
   logic [31:0] store_data;
   logic [2:0]  store_bytes;
   logic [31:0] next_pc;
   modport source (output valid, result_kind, mem_address, store_data, store_bytes,
      next_pc, input ready);
   modport sink (input valid, result_kind, mem_address, store_data, store_bytes,
      next_pc, output ready);
endinterface

>>> sv/rvx_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the start address register.
// ----------------------------------------------------------------------------
interface rvx_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> sv/rvx_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register file
// Two synchronous read ports and one write port; reads are registered.
// ----------------------------------------------------------------------------
module rvx_regfile #(
   parameter int unsigned REG_COUNT = rvx_pkg::REG_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [4:0]            rs1_addr,
   input  logic [4:0]            rs2_addr,
   output logic [31:0]           rs1_data,
   output logic [31:0]           rs2_data,
   input  rvx_pkg::rf_write_type wr
);
   import rvx_pkg::*;

   localparam int unsigned AW = $clog2(REG_COUNT);

   logic [31:0] mem_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (wr.we && ({27'd0, wr.addr} < REG_COUNT)) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rs1_data <= mem_ff[rs1_addr[AW-1:0]];
         rs2_data <= mem_ff[rs2_addr[AW-1:0]];
      end
   end

endmodule

>>> sv/rvx_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execute logic
// Decodes one instruction and computes its result, register write and next pc.
// ----------------------------------------------------------------------------
module rvx_alu (
   input  logic [31:0]           instr,
   input  logic [31:0]           pc,
   input  logic [31:0]           a,
   input  logic [31:0]           b,
   output rvx_pkg::kind_type     kind,
   output logic [31:0]           addr,
   output logic [31:0]           sdata,
   output logic [2:0]            sbytes,
   output logic [31:0]           next,
   output rvx_pkg::rf_write_type wr,
   output logic                  load_start
);
   import rvx_pkg::*;

   logic [6:0]  op;
   logic [6:0]  f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] immi, imms, immb, immj, immu, opb, alu_res, pc4;
   logic        alt, take, lts, ltu;
   logic [4:0]  sh;

   always_comb begin
      op = instr[6:0];
      rd = instr[11:7];
      f3 = instr[14:12];
      f7 = instr[31:25];
      immi = {{20{instr[31]}}, instr[31:20]};
      imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
      immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
      immu = {instr[31:12], 12'd0};
      pc4 = pc + 32'd4;
      if (op == OP_IMM) begin
         opb = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, instr[24:20]} : immi;
         alt = (f3 == 3'd5) && f7[5];
      end else begin
         opb = b;
         alt = (f3 == 3'd0 || f3 == 3'd5) && (f7 == 7'h20);
      end
      sh = opb[4:0] & SHAMT_MASK;
      lts = $signed(a) < $signed(opb);
      ltu = a < opb;
      case (f3)
         3'd0: alu_res = alt ? a - opb : a + opb;
         3'd1: alu_res = a << sh;
         3'd2: alu_res = {31'd0, lts};
         3'd3: alu_res = {31'd0, ltu};
         3'd4: alu_res = a ^ opb;
         3'd5: alu_res = alt ? 32'($signed(a) >>> sh) : a >> sh;
         3'd6: alu_res = a | opb;
         default: alu_res = a & opb;
      endcase

      kind = KIND_RETIRED;
      addr = 32'd0;
      sdata = 32'd0;
      sbytes = 3'd0;
      next = pc4;
      wr.we = 1'b0;
      wr.addr = rd;
      wr.data = alu_res;
      load_start = 1'b0;
      take = 1'b0;
      case (op)
         OP_LUI: begin
            wr.we = 1'b1;
            wr.data = immu;
         end
         OP_AUIPC: begin
            wr.we = 1'b1;
            wr.data = pc + immu;
         end
         OP_JAL: begin
            wr.we = 1'b1;
            wr.data = pc4;
            next = pc + immj;
         end
         OP_JALR: begin
            if (f3 != 3'd0) begin
               kind = KIND_ILLEGAL;
            end else begin
               wr.we = 1'b1;
               wr.data = pc4;
               next = (a + immi) & ~32'd1;
            end
         end
         OP_BRANCH: begin
            case (f3)
               3'd0: take = (a == b);
               3'd1: take = (a != b);
               3'd4: take = $signed(a) < $signed(b);
               3'd5: take = !($signed(a) < $signed(b));
               3'd6: take = a < b;
               3'd7: take = a >= b;
               default: kind = KIND_ILLEGAL;
            endcase
            if (take) begin
               next = pc + immb;
            end
         end
         OP_LOAD: begin
            if (f3 == 3'd3 || f3 > 3'd5) begin
               kind = KIND_ILLEGAL;
            end else begin
               kind = KIND_LOAD;
               addr = a + immi;
               load_start = 1'b1;
            end
         end
         OP_STORE: begin
            if (f3 > 3'd2) begin
               kind = KIND_ILLEGAL;
            end else begin
               kind = KIND_STORE;
               addr = a + imms;
               sbytes = 3'd1 << f3[1:0];
               case (f3)
                  3'd0: sdata = {24'd0, b[7:0]};
                  3'd1: sdata = {16'd0, b[15:0]};
                  default: sdata = b;
               endcase
            end
         end
         OP_IMM: begin
            wr.we = 1'b1;
            if (f3 == 3'd4 && immi == 32'hFFFF_FFFF) begin
               wr.data = ~a;
            end
         end
         OP_REG: begin
            if ((f3 == 3'd0 || f3 == 3'd5) && f7 != 7'h00 && f7 != 7'h20) begin
               kind = KIND_ILLEGAL;
            end else begin
               wr.we = 1'b1;
            end
         end
         OP_FENCE, OP_SYSTEM: begin
         end
         default: kind = KIND_ILLEGAL;
      endcase
      if (kind == KIND_ILLEGAL) begin
         next = pc;
         addr = 32'd0;
         wr.we = 1'b0;
      end
      if (rd == 5'd0) begin
         wr.we = 1'b0;
      end
   end

endmodule

>>> sv/rv32i_integer_core_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute block
// Executes base-integer instructions against a memory-based register file.
// ----------------------------------------------------------------------------
// Usage: req carries one item, an instruction word fetched at the current pc
// or the data returned for a pending load. rsp carries one result item per
// request item: retired, load request, store request, illegal or unexpected,
// with the next pc to fetch. csr writes the start address, which loads the pc
// and x5 at once; write it only while the block is idle.
// Each item passes the register file read register, then execute into the
// response register. A new item is taken every cycle unless rsp stalls; a
// result written to the register file by the item just executed is
// forwarded to the reads of the following item.
// Reset clears the pc, x5 and the load state to zero, and sweeps every
// register file entry to zero while req.ready and csr.ready stay low.
// When rsp stalls, the response register holds and the execute stage waits;
// req.ready drops once the read stage also holds an item.
// ----------------------------------------------------------------------------
module rv32i_integer_core_execute #(
   parameter int unsigned REG_COUNT = rvx_pkg::REG_COUNT_DEFAULT
) (
   input logic clock,
   input logic reset,
   rvx_req_if.sink   req,
   rvx_rsp_if.source rsp,
   rvx_csr_if.sink   csr
);
   import rvx_pkg::*;

   localparam int unsigned CW = $clog2(REG_COUNT) + 1;

   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clearing;
   logic [31:0]   pc_ff, pc_in;
   logic          lp_ff, lp_in;
   logic [4:0]    ld_rd_ff, ld_rd_in;
   logic [2:0]    ld_f3_ff, ld_f3_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_kind_ff;
   logic [31:0]   s1_instr_ff, s1_data_ff;

   logic          rv_ff, rv_in;
   logic [2:0]    r_kind_ff;
   logic [31:0]   r_addr_ff, r_sdata_ff, r_next_ff;
   logic [2:0]    r_bytes_ff;

   logic          adv, take_in;
   logic [31:0]   rs1_raw, rs2_raw, a, b;
   logic [4:0]    rs1_q_ff, rs2_q_ff;
   rf_write_type  last_wr_ff, ex_wr, rf_wr;

   kind_type      e_kind;
   logic [31:0]   e_addr, e_sdata, e_next, ld_val;
   logic [2:0]    e_bytes;
   rf_write_type  alu_wr;
   logic          alu_load;
   kind_type      x_kind;
   logic [31:0]   x_addr, x_sdata, x_next;
   logic [2:0]    x_bytes;
   logic          csr_wr;

   assign clearing = (clr_cnt_ff != CW'(REG_COUNT));
   assign adv = s1_valid_ff && (!rv_ff || rsp.ready);
   assign req.ready = !clearing && (!s1_valid_ff || adv);
   assign take_in = req.valid && req.ready;
   assign csr.ready = !clearing;
   assign csr_wr = csr.valid && csr.ready;

   always_comb begin
      a = (last_wr_ff.we && last_wr_ff.addr == rs1_q_ff) ? last_wr_ff.data : rs1_raw;
      b = (last_wr_ff.we && last_wr_ff.addr == rs2_q_ff) ? last_wr_ff.data : rs2_raw;
      if (rs1_q_ff == 5'd0 || {27'd0, rs1_q_ff} >= REG_COUNT) a = 32'd0;
      if (rs2_q_ff == 5'd0 || {27'd0, rs2_q_ff} >= REG_COUNT) b = 32'd0;
   end

   rvx_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
      .clock    (clock),
      .rd_en    (take_in),
      .rs1_addr (req.instr_word[19:15]),
      .rs2_addr (req.instr_word[24:20]),
      .rs1_data (rs1_raw),
      .rs2_data (rs2_raw),
      .wr       (rf_wr)
   );

   rvx_alu u_alu (
      .instr      (s1_instr_ff),
      .pc         (pc_ff),
      .a          (a),
      .b          (b),
      .kind       (e_kind),
      .addr       (e_addr),
      .sdata      (e_sdata),
      .sbytes     (e_bytes),
      .next       (e_next),
      .wr         (alu_wr),
      .load_start (alu_load)
   );

   always_comb begin
      case (ld_f3_ff)
         F3_B:  ld_val = {{24{s1_data_ff[7]}}, s1_data_ff[7:0]};
         F3_H:  ld_val = {{16{s1_data_ff[15]}}, s1_data_ff[15:0]};
         F3_BU: ld_val = {24'd0, s1_data_ff[7:0]};
         F3_HU: ld_val = {16'd0, s1_data_ff[15:0]};
         default: ld_val = s1_data_ff;
      endcase
      x_kind = KIND_RETIRED;
      x_addr = 32'd0;
      x_sdata = 32'd0;
      x_bytes = 3'd0;
      x_next = pc_ff;
      ex_wr.we = 1'b0;
      ex_wr.addr = ld_rd_ff;
      ex_wr.data = ld_val;
      pc_in = pc_ff;
      lp_in = lp_ff;
      ld_rd_in = ld_rd_ff;
      ld_f3_in = ld_f3_ff;
      if (s1_kind_ff == ITEM_LOAD_DATA) begin
         if (!lp_ff) begin
            x_kind = KIND_UNEXPECTED;
         end else begin
            ex_wr.we = (ld_rd_ff != 5'd0);
            lp_in = 1'b0;
         end
      end else if (lp_ff) begin
         x_kind = KIND_UNEXPECTED;
      end else begin
         x_kind = e_kind;
         x_addr = e_addr;
         x_sdata = e_sdata;
         x_bytes = e_bytes;
         x_next = e_next;
         ex_wr = alu_wr;
         pc_in = e_next;
         if (alu_load) begin
            lp_in = 1'b1;
            ld_rd_in = s1_instr_ff[11:7];
            ld_f3_in = s1_instr_ff[14:12];
         end
      end
      if (!adv) begin
         ex_wr.we = 1'b0;
         pc_in = pc_ff;
         lp_in = lp_ff;
         ld_rd_in = ld_rd_ff;
         ld_f3_in = ld_f3_ff;
      end
      if (csr_wr) begin
         pc_in = csr.data;
      end
      if (clearing) begin
         rf_wr.we = 1'b1;
         rf_wr.addr = clr_cnt_ff[4:0];
         rf_wr.data = 32'd0;
      end else if (csr_wr) begin
         rf_wr.we = 1'b1;
         rf_wr.addr = 5'd5;
         rf_wr.data = csr.data;
      end else begin
         rf_wr = ex_wr;
      end
      s1_valid_in = take_in || (s1_valid_ff && !adv);
      rv_in = adv || (rv_ff && !rsp.ready);
      clr_cnt_in = clearing ? clr_cnt_ff + CW'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         pc_ff <= 32'd0;
         lp_ff <= 1'b0;
         ld_rd_ff <= 5'd0;
         ld_f3_ff <= 3'd0;
         s1_valid_ff <= 1'b0;
         rv_ff <= 1'b0;
         last_wr_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         pc_ff <= pc_in;
         lp_ff <= lp_in;
         ld_rd_ff <= ld_rd_in;
         ld_f3_ff <= ld_f3_in;
         s1_valid_ff <= s1_valid_in;
         rv_ff <= rv_in;
         last_wr_ff <= take_in ? rf_wr : (rf_wr.we ? rf_wr : last_wr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_kind_ff <= req.item_kind;
         s1_instr_ff <= req.instr_word;
         s1_data_ff <= req.load_data;
         rs1_q_ff <= req.instr_word[19:15];
         rs2_q_ff <= req.instr_word[24:20];
      end
      if (adv) begin
         r_kind_ff <= x_kind;
         r_addr_ff <= x_addr;
         r_sdata_ff <= x_sdata;
         r_bytes_ff <= x_bytes;
         r_next_ff <= x_next;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.result_kind = r_kind_ff;
   assign rsp.mem_address = r_addr_ff;
   assign rsp.store_data = r_sdata_ff;
   assign rsp.store_bytes = r_bytes_ff;
   assign rsp.next_pc = r_next_ff;

   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req.ready) else $error("item taken during clear");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.next_pc))
      else $error("result lost under stall");
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !adv && !csr_wr |=> $stable(pc_ff)) else $error("pc moved without item");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.result_kind <= KIND_UNEXPECTED) else $error("bad kind");

endmodule

>>> bench/rvx_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute checker
// Watches the request, response and start address channels, keeps its own
// register file, pc and load state, predicts one result per accepted request
// and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module rvx_exec_checker
   import rvx_pkg::*;
#(
   parameter int unsigned REG_COUNT = 32
) (
   input logic clock,
   input logic reset,
   rvx_req_if  req,
   rvx_rsp_if  rsp,
   rvx_csr_if  csr,
   output int  errors,
   output int  outstanding
);

   typedef struct packed {
      kind_type    kind;
      logic [31:0] addr;
      logic [31:0] sdata;
      logic [2:0]  nbytes;
      logic [31:0] npc;
   } exec_result_type;

   logic [31:0] regs [32];
   logic [31:0] pc_now;
   logic        load_wait;
   logic [4:0]  load_rd;
   logic [2:0]  load_f3;
   exec_result_type results_due [$];

   function automatic logic [31:0] read_reg(input logic [4:0] idx);
      if (idx == 5'd0 || idx >= REG_COUNT) return 32'd0;
      return regs[idx];
   endfunction

   task automatic write_reg(input logic [4:0] idx, input logic [31:0] val);
      if (idx != 5'd0 && idx < REG_COUNT) regs[idx] = val;
   endtask

   function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                       input logic [31:0] a, input logic [31:0] b);
      case (f3)
         3'd0: return alt ? a - b : a + b;
         3'd1: return a << b[4:0];
         3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         3'd3: return (a < b) ? 32'd1 : 32'd0;
         3'd4: return a ^ b;
         3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: return a | b;
         default: return a & b;
      endcase
   endfunction

   task automatic execute(input logic kind_in, input logic [31:0] w,
                          input logic [31:0] d, output exec_result_type r);
      logic [31:0] a, b, immi, imms, immb, immj, nxt;
      logic [6:0]  op, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic        take;
      r = '0;
      r.kind = KIND_RETIRED;
      nxt = pc_now;
      if (kind_in == ITEM_LOAD_DATA) begin
         if (!load_wait) begin
            r.kind = KIND_UNEXPECTED;
         end else begin
            case (load_f3)
               F3_B: d = {{24{d[7]}}, d[7:0]};
               F3_H: d = {{16{d[15]}}, d[15:0]};
               F3_BU: d = {24'd0, d[7:0]};
               F3_HU: d = {16'd0, d[15:0]};
               default: ;
            endcase
            write_reg(load_rd, d);
            load_wait = 1'b0;
         end
      end else if (load_wait) begin
         r.kind = KIND_UNEXPECTED;
      end else begin
         op = w[6:0];
         rd = w[11:7];
         f3 = w[14:12];
         f7 = w[31:25];
         a = read_reg(w[19:15]);
         b = read_reg(w[24:20]);
         immi = {{20{w[31]}}, w[31:20]};
         imms = {{20{w[31]}}, w[31:25], w[11:7]};
         immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         take = 1'b0;
         nxt = pc_now + 32'd4;
         case (op)
            OP_LUI: write_reg(rd, {w[31:12], 12'd0});
            OP_AUIPC: write_reg(rd, pc_now + {w[31:12], 12'd0});
            OP_JAL: begin
               write_reg(rd, pc_now + 32'd4);
               nxt = pc_now + immj;
            end
            OP_JALR: begin
               if (f3 != 3'd0) r.kind = KIND_ILLEGAL;
               else begin
                  nxt = (a + immi) & ~32'd1;
                  write_reg(rd, pc_now + 32'd4);
               end
            end
            OP_BRANCH: begin
               case (f3)
                  3'd0: take = (a == b);
                  3'd1: take = (a != b);
                  3'd4: take = ($signed(a) < $signed(b));
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = (a < b);
                  3'd7: take = (a >= b);
                  default: r.kind = KIND_ILLEGAL;
               endcase
               if (take) nxt = pc_now + immb;
            end
            OP_LOAD: begin
               if (f3 == 3'd3 || f3 > 3'd5) r.kind = KIND_ILLEGAL;
               else begin
                  r.kind = KIND_LOAD;
                  r.addr = a + immi;
                  load_wait = 1'b1;
                  load_rd = rd;
                  load_f3 = f3;
               end
            end
            OP_STORE: begin
               if (f3 > 3'd2) r.kind = KIND_ILLEGAL;
               else begin
                  r.kind = KIND_STORE;
                  r.addr = a + imms;
                  r.nbytes = 3'(1 << f3);
                  r.sdata = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                            (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
               end
            end
            OP_IMM: begin
               if (f3 == 3'd4 && immi == 32'hFFFF_FFFF) write_reg(rd, ~a);
               else write_reg(rd, alu(f3, f3 == 3'd5 && f7[5], a,
                              (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, w[24:20]} : immi));
            end
            OP_REG: begin
               if ((f3 == 3'd0 || f3 == 3'd5) && f7 != 7'h00 && f7 != 7'h20)
                  r.kind = KIND_ILLEGAL;
               else write_reg(rd, alu(f3, (f3 == 3'd0 || f3 == 3'd5) && f7 == 7'h20, a, b));
            end
            OP_FENCE, OP_SYSTEM: ;
            default: r.kind = KIND_ILLEGAL;
         endcase
         if (r.kind == KIND_ILLEGAL) begin
            nxt = pc_now;
            r.addr = '0;
         end else begin
            pc_now = nxt;
         end
      end
      r.npc = nxt;
   endtask

   always @(posedge clock) begin
      exec_result_type got, want;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         pc_now = '0;
         load_wait = 1'b0;
         load_rd = '0;
         load_f3 = '0;
         results_due.delete();
         errors = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            pc_now = csr.data;
            write_reg(5'd5, csr.data);
         end
         if (rsp.valid && rsp.ready) begin
            got.kind = kind_type'(rsp.result_kind);
            got.addr = rsp.mem_address;
            got.sdata = rsp.store_data;
            got.nbytes = rsp.store_bytes;
            got.npc = rsp.next_pc;
            if (results_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("checker: result with none expected: %p", got);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("checker: expected %p, got %p", want, got);
               end
            end
         end
         if (req.valid && req.ready) begin
            execute(req.item_kind, req.instr_word, req.load_data, want);
            results_due.push_back(want);
         end
      end
      outstanding = results_due.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute testbench
// Drives directed and random instruction and load data items under random
// idling on both sides, across several start addresses, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import rvx_pkg::*;

   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, outstanding, cycles = 0, sent = 0;
   int   gap_max = 0, stall_max = 0;

   rvx_req_if req ();
   rvx_rsp_if rsp ();
   rvx_csr_if csr ();

   rv32i_integer_core_execute u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr(csr));
   rvx_exec_checker u_checker (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr(csr), .errors(errors), .outstanding(outstanding));

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
         input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   task automatic send(input logic kind_in, input logic [31:0] w, input logic [31:0] d);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.item_kind = kind_in;
      req.instr_word = w;
      req.load_data = d;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      sent++;
      if (sent % 64 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
   endtask

   task automatic instr(input logic [31:0] w);
      send(ITEM_INSTR, w, $urandom());
   endtask

   task automatic data(input logic [31:0] d);
      send(ITEM_LOAD_DATA, $urandom(), d);
   endtask

   task automatic drain();
      req.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_start(input logic [31:0] addr);
      drain();
      csr.valid = 1'b1;
      csr.data = addr;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic send_random();
      int sel;
      logic [2:0] f3;
      sel = $urandom_range(0, 99);
      f3 = 3'($urandom_range(0, 7));
      if (sel < 12) begin
         instr({20'($urandom_range(0, 32'hFFFFF)), 5'($urandom()), OP_LUI});
      end else if (sel < 24) begin
         instr(enc_i(12'($urandom()), 5'($urandom()), f3, 5'($urandom()), OP_IMM));
      end else if (sel < 36) begin
         instr(enc_r(($urandom_range(0, 9) == 0) ? 7'($urandom()) :
                     ($urandom_range(0, 1) ? 7'h20 : 7'h00),
                     5'($urandom()), 5'($urandom()), f3, 5'($urandom())));
      end else if (sel < 48) begin
         if ($urandom_range(0, 7) != 0) begin
            case ($urandom_range(0, 4))
               0: f3 = F3_B;
               1: f3 = F3_H;
               2: f3 = F3_W;
               3: f3 = F3_BU;
               default: f3 = F3_HU;
            endcase
         end
         instr(enc_i(12'($urandom()), 5'($urandom()), f3, 5'($urandom()), OP_LOAD));
         if ($urandom_range(0, 9) != 0) data($urandom());
      end else if (sel < 58) begin
         if ($urandom_range(0, 5) != 0) f3 = 3'($urandom_range(0, 2));
         instr(enc_s(12'($urandom()), 5'($urandom()), 5'($urandom()), f3));
      end else if (sel < 68) begin
         instr(enc_b(13'($urandom()), 5'($urandom()), 5'($urandom()), f3));
      end else if (sel < 72) begin
         instr(enc_j(21'($urandom()), 5'($urandom())));
      end else if (sel < 77) begin
         if ($urandom_range(0, 4) != 0) f3 = 3'd0;
         instr(enc_i(12'($urandom()), 5'($urandom()), f3, 5'($urandom()), OP_JALR));
      end else if (sel < 80) begin
         instr({20'($urandom_range(0, 32'hFFFFF)), 5'($urandom()), OP_AUIPC});
      end else if (sel < 83) begin
         instr({25'($urandom()), $urandom_range(0, 1) ? OP_FENCE : OP_SYSTEM});
      end else if (sel < 87) begin
         data($urandom());
      end else if (sel < 93) begin
         instr($urandom());
      end else begin
         instr(enc_i($urandom_range(0, 1) ? 12'hFFF : {7'($urandom()), 5'($urandom())},
                     5'($urandom()), $urandom_range(0, 1) ? 3'd4 :
                     ($urandom_range(0, 1) ? 3'd1 : 3'd5), 5'($urandom()), OP_IMM));
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.item_kind = ITEM_INSTR;
      req.instr_word = '0;
      req.load_data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_start(32'h0000_0000);
      instr({20'h80000, 5'd1, OP_LUI});
      instr(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM));
      instr(enc_r(7'h00, 5'd2, 5'd1, 3'd0, 5'd3));
      instr(enc_r(7'h20, 5'd1, 5'd0, 3'd0, 5'd4));
      instr(enc_r(7'h20, 5'd2, 5'd1, 3'd5, 5'd6));
      instr(enc_i({7'h20, 5'd31}, 5'd1, 3'd5, 5'd7, OP_IMM));
      instr(enc_i(12'hFFF, 5'd1, 3'd4, 5'd8, OP_IMM));
      instr(enc_r(7'h00, 5'd0, 5'd1, 3'd2, 5'd9));
      instr(enc_i(12'd0, 5'd5, F3_B, 5'd11, OP_LOAD));
      data(32'h0000_0080);
      instr(enc_i(12'h7FF, 5'd1, F3_HU, 5'd12, OP_LOAD));
      data(32'hFFFF_8000);
      instr(enc_i(12'h800, 5'd2, 3'd3, 5'd12, OP_LOAD));
      data(32'h1234_5678);
      instr(enc_i(12'd4, 5'd1, F3_H, 5'd13, OP_LOAD));
      instr(enc_r(7'h00, 5'd2, 5'd1, 3'd0, 5'd3));
      data(32'h0000_8001);
      instr(enc_s(12'hFFF, 5'd2, 5'd1, 3'd0));
      instr(enc_s(12'h7FF, 5'd2, 5'd1, 3'd1));
      instr(enc_s(12'h800, 5'd1, 5'd2, 3'd2));
      instr(enc_b(13'h1FFC, 5'd0, 5'd0, 3'd0));
      instr(enc_b(13'h0010, 5'd0, 5'd0, 3'd2));
      instr(enc_j(21'h0FFFFE, 5'd1));
      instr(enc_i(12'd0, 5'd2, 3'd1, 5'd1, OP_JALR));
      instr(enc_i(12'hFFF, 5'd2, 3'd0, 5'd14, OP_JALR));
      instr(enc_r(7'h01, 5'd2, 5'd1, 3'd0, 5'd15));
      instr({25'd0, 7'h7F});
      instr({25'd0, OP_FENCE});
      instr({25'd0, OP_SYSTEM});
      instr(enc_i(12'd5, 5'd1, 3'd0, 5'd0, OP_IMM));
      instr({20'hFFFFF, 5'd16, OP_AUIPC});

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: set_start(32'hFFFF_FFFF);
            2: set_start(32'hFFFF_FFFC);
            3: set_start(32'h8000_0000);
            4: set_start($urandom());
            default: ;
         endcase
         repeat (200) begin
            send_random();
            if (sent == 500) drain();
         end
      end

      req.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready = 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      end
   end

endmodule
